// File: rtl/rbt_pkg.sv
// shared types and codes for the resource borrow tracker
`timescale 1ns / 1ps

package rbt_pkg;

  localparam int PROC_W  = 16;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int CLEAN_W = 12;

  localparam logic [3:0] CMD_QUERY     = 4'd0;
  localparam logic [3:0] CMD_ACQUIRE   = 4'd1;
  localparam logic [3:0] CMD_RELEASE   = 4'd2;
  localparam logic [3:0] CMD_TRANSFER  = 4'd3;
  localparam logic [3:0] CMD_BORROW_SH = 4'd4;
  localparam logic [3:0] CMD_BORROW_MT = 4'd5;
  localparam logic [3:0] CMD_RETURN_SH = 4'd6;
  localparam logic [3:0] CMD_RETURN_MT = 4'd7;
  localparam logic [3:0] CMD_CLEANUP   = 4'd8;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_INVALID      = 4'd1;
  localparam logic [3:0] ST_FULL         = 4'd2;
  localparam logic [3:0] ST_HELD         = 4'd3;
  localparam logic [3:0] ST_NOTFOUND     = 4'd4;
  localparam logic [3:0] ST_NOTOWNER     = 4'd5;
  localparam logic [3:0] ST_BORROWED     = 4'd6;
  localparam logic [3:0] ST_MUTBORROW    = 4'd7;
  localparam logic [3:0] ST_SHAREDBORROW = 4'd8;
  localparam logic [3:0] ST_NOTBORROWED  = 4'd9;
  localparam logic [3:0] ST_COUNTFULL    = 4'd10;

  localparam logic [1:0] MODE_FREE   = 2'd0;
  localparam logic [1:0] MODE_EXCL   = 2'd1;
  localparam logic [1:0] MODE_SHARED = 2'd2;
  localparam logic [1:0] MODE_MUT    = 2'd3;

  localparam logic [CNT_W-1:0]   SHARED_MAX = '1;
  localparam logic [CLEAN_W-1:0] CLEAN_MAX  = '1;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [PROC_W-1:0]  owner;
    logic [1:0]         mode;
    logic [CNT_W-1:0]   shared;
    logic [PROC_W-1:0]  mut;
    logic [TOTAL_W-1:0] total;
  } entry_t;

  typedef struct packed {
    logic load;
    logic home;
    logic rd;
    logic chk;
    logic exec;
    logic clr;
    logic cl_chk;
  } ctl_t;

  typedef struct packed {
    logic home_done;
    logic scan_done;
    logic clean;
    logic clr_last;
    logic cl_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/rbt_ctrl.sv
// command sequencer for the resource borrow tracker
`timescale 1ns / 1ps

module rbt_ctrl import rbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HOME   = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_CL_RD  = 4'd5;
  localparam logic [3:0] S_CL_CHK = 4'd6;
  localparam logic [3:0] S_EXEC   = 4'd7;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        ctl.home = 1'b1;
        if (sts.home_done) state_nxt = sts.clean ? S_CL_RD : S_RD;
      end
      S_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        ctl.chk   = 1'b1;
        state_nxt = sts.scan_done ? S_EXEC : S_RD;
      end
      S_CL_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = S_CL_CHK;
      end
      S_CL_CHK: begin
        ctl.cl_chk = 1'b1;
        state_nxt  = sts.cl_last ? S_EXEC : S_CL_RD;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rbt_dp.sv
// table memory, probe logic, command execution and result register
`timescale 1ns / 1ps

module rbt_dp import rbt_pkg::*; #(
  parameter int ENTRIES   = 1024,
  parameter int PROC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         command,
  input  logic [KEY_W-1:0]   resource_key,
  input  logic [PROC_W-1:0]  first_proc,
  input  logic [PROC_W-1:0]  second_proc,
  input  ctl_t               ctl,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         status,
  output logic               entry_found,
  output logic [1:0]         entry_state_out,
  output logic [PROC_W-1:0]  owner_out,
  output logic [CNT_W-1:0]   shared_out,
  output logic [PROC_W-1:0]  mut_borrower_out,
  output logic [TOTAL_W-1:0] borrow_total_out,
  output logic               can_share,
  output logic               can_mut,
  output logic [CLEAN_W-1:0] cleaned_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = AW + 1;
  localparam bit POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [RW-1:0] MODV = RW'(ENTRIES);
  localparam logic [PROC_W-1:0] PMASK =
    (PROC_BITS >= PROC_W) ? '1 : PROC_W'((64'd1 << PROC_BITS) - 64'd1);

  entry_t mem [ENTRIES];

  logic [3:0]         cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [PROC_W-1:0]  a_r, b_r;
  logic               clean_r;
  logic [AW-1:0]      rem_r;
  logic [4:0]         bit_r;
  logic [AW-1:0]      idx_r, cnt_r, fidx_r, free_idx_r;
  logic               found_r, free_seen_r;
  entry_t             ent_r, rdata_r;
  logic [CLEAN_W-1:0] cleaned_r;
  logic               out_valid_r;

  logic [RW-1:0] sh, sub;
  logic [AW-1:0] rem_nxt, home_idx, idx_inc;
  logic          match;

  assign sh       = {rem_r, key_r[~bit_r]};
  assign sub      = sh - MODV;
  assign rem_nxt  = (sh >= MODV) ? sub[AW-1:0] : sh[AW-1:0];
  assign home_idx = POW2 ? key_r[AW-1:0] : rem_nxt;
  assign idx_inc  = (idx_r == LAST) ? '0 : idx_r + 1'b1;
  assign match    = rdata_r.valid && (rdata_r.key == key_r);

  assign sts.home_done = clean_r || POW2 || (bit_r == 5'd31);
  assign sts.scan_done = match || (cnt_r == LAST);
  assign sts.clean     = clean_r;
  assign sts.clr_last  = (idx_r == LAST);
  assign sts.cl_last   = (idx_r == LAST);
  assign sts.out_free  = !out_valid_r || out_ready;

  // cleanup of one entry
  entry_t cl_new;
  logic   cl_inc;
  always_comb begin
    cl_new = rdata_r;
    cl_inc = 1'b0;
    if (rdata_r.owner == a_r) begin
      cl_new.owner  = '0;
      cl_new.mode   = MODE_FREE;
      cl_new.shared = '0;
      cl_new.mut    = '0;
      cl_inc        = 1'b1;
    end else if (rdata_r.mut == a_r) begin
      cl_new.mut = '0;
      if (rdata_r.mode == MODE_MUT) cl_new.mode = MODE_EXCL;
      cl_inc = 1'b1;
    end
    if (cl_new.mode == MODE_FREE && cl_new.shared == '0 && cl_new.mut == '0) begin
      cl_new.valid = 1'b0;
    end
  end

  // command execution on the located entry
  logic [3:0]    ex_st;
  logic          ex_we, ex_pres;
  logic [AW-1:0] ex_widx;
  entry_t        ex_new;
  always_comb begin
    ex_st   = ST_OK;
    ex_we   = 1'b0;
    ex_pres = found_r;
    ex_widx = fidx_r;
    ex_new  = ent_r;
    case (cmd_r)
      CMD_QUERY: ;
      CMD_ACQUIRE: begin
        if (a_r == '0) begin
          ex_st = ST_INVALID;
        end else if (found_r) begin
          if (ent_r.mode != MODE_FREE) begin
            ex_st = ST_HELD;
          end else begin
            ex_new.owner = a_r;
            ex_new.mode  = MODE_EXCL;
            ex_we        = 1'b1;
          end
        end else if (free_seen_r) begin
          ex_new  = '{valid: 1'b1, key: key_r, owner: a_r, mode: MODE_EXCL,
                      shared: '0, mut: '0, total: '0};
          ex_we   = 1'b1;
          ex_widx = free_idx_r;
          ex_pres = 1'b1;
        end else begin
          ex_st = ST_FULL;
        end
      end
      CMD_RELEASE, CMD_TRANSFER: begin
        if (a_r == '0 || (cmd_r == CMD_TRANSFER && b_r == '0)) ex_st = ST_INVALID;
        else if (!found_r) ex_st = ST_NOTFOUND;
        else if (ent_r.owner != a_r) ex_st = ST_NOTOWNER;
        else if (ent_r.shared != '0 || ent_r.mut != '0) ex_st = ST_BORROWED;
        else begin
          ex_we = 1'b1;
          if (cmd_r == CMD_RELEASE) begin
            ex_new.owner = '0;
            ex_new.mode  = MODE_FREE;
          end else begin
            ex_new.owner = b_r;
          end
        end
      end
      CMD_BORROW_SH: begin
        if (a_r == '0 || b_r == '0) ex_st = ST_INVALID;
        else if (!found_r) ex_st = ST_NOTFOUND;
        else if (ent_r.owner != a_r) ex_st = ST_NOTOWNER;
        else if (ent_r.mut != '0) ex_st = ST_MUTBORROW;
        else if (ent_r.shared == SHARED_MAX) ex_st = ST_COUNTFULL;
        else begin
          ex_we         = 1'b1;
          ex_new.shared = ent_r.shared + 1'b1;
          ex_new.total  = ent_r.total + 1'b1;
          if (ent_r.mode == MODE_EXCL) ex_new.mode = MODE_SHARED;
        end
      end
      CMD_BORROW_MT: begin
        if (a_r == '0 || b_r == '0) ex_st = ST_INVALID;
        else if (!found_r) ex_st = ST_NOTFOUND;
        else if (ent_r.owner != a_r) ex_st = ST_NOTOWNER;
        else if (ent_r.shared != '0) ex_st = ST_SHAREDBORROW;
        else if (ent_r.mut != '0) ex_st = ST_MUTBORROW;
        else begin
          ex_we        = 1'b1;
          ex_new.mut   = b_r;
          ex_new.mode  = MODE_MUT;
          ex_new.total = ent_r.total + 1'b1;
        end
      end
      CMD_RETURN_SH: begin
        if (b_r == '0) ex_st = ST_INVALID;
        else if (!found_r) ex_st = ST_NOTFOUND;
        else if (ent_r.shared == '0) ex_st = ST_NOTBORROWED;
        else begin
          ex_we         = 1'b1;
          ex_new.shared = ent_r.shared - 1'b1;
          if (ent_r.shared == CNT_W'(1)) ex_new.mode = MODE_EXCL;
        end
      end
      CMD_RETURN_MT: begin
        if (b_r == '0) ex_st = ST_INVALID;
        else if (!found_r) ex_st = ST_NOTFOUND;
        else if (ent_r.mut != b_r) ex_st = ST_NOTBORROWED;
        else begin
          ex_we       = 1'b1;
          ex_new.mut  = '0;
          ex_new.mode = MODE_EXCL;
        end
      end
      default: ex_st = ST_INVALID;
    endcase
    if (clean_r) begin
      ex_st   = ST_OK;
      ex_we   = 1'b0;
      ex_pres = found_r;
      ex_new  = ent_r;
    end
  end

  // memory write port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = rdata_r;
    if (ctl.clr) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (ctl.cl_chk) begin
      mem_we    = rdata_r.valid;
      mem_wdata = cl_new;
    end else if (ctl.exec) begin
      mem_we    = ex_we;
      mem_waddr = ex_widx;
      mem_wdata = ex_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (ctl.rd) rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clr) idx_r <= idx_inc;
      if (ctl.load) begin
        cmd_r   <= command;
        key_r   <= resource_key;
        a_r     <= first_proc & PMASK;
        b_r     <= second_proc & PMASK;
        clean_r <= (command == CMD_CLEANUP) && ((first_proc & PMASK) != '0);
        rem_r   <= '0;
        bit_r   <= '0;
      end
      if (ctl.home) begin
        rem_r <= rem_nxt;
        bit_r <= bit_r + 1'b1;
        if (sts.home_done) begin
          idx_r       <= clean_r ? '0 : home_idx;
          cnt_r       <= '0;
          found_r     <= 1'b0;
          free_seen_r <= 1'b0;
          cleaned_r   <= '0;
        end
      end
      if (ctl.chk) begin
        idx_r <= idx_inc;
        cnt_r <= cnt_r + 1'b1;
        if (match) begin
          found_r <= 1'b1;
          fidx_r  <= idx_r;
          ent_r   <= rdata_r;
        end else if (!rdata_r.valid && !free_seen_r) begin
          free_seen_r <= 1'b1;
          free_idx_r  <= idx_r;
        end
      end
      if (ctl.cl_chk) begin
        idx_r <= idx_inc;
        if (rdata_r.valid && cl_inc && cleaned_r != CLEAN_MAX) cleaned_r <= cleaned_r + 1'b1;
        if (cl_new.valid && cl_new.key == key_r) begin
          found_r <= 1'b1;
          ent_r   <= cl_new;
        end
      end
      if (ctl.exec) begin
        out_valid_r      <= 1'b1;
        status           <= ex_st;
        entry_found      <= ex_pres;
        entry_state_out  <= ex_pres ? ex_new.mode : MODE_FREE;
        owner_out        <= ex_pres ? ex_new.owner : '0;
        shared_out       <= ex_pres ? ex_new.shared : '0;
        mut_borrower_out <= ex_pres ? ex_new.mut : '0;
        borrow_total_out <= ex_pres ? ex_new.total : '0;
        can_share        <= ex_pres && ex_new.mode != MODE_FREE && ex_new.mut == '0;
        can_mut          <= ex_pres && ex_new.mode != MODE_FREE && ex_new.mut == '0
                            && ex_new.shared == '0;
        cleaned_count    <= clean_r ? cleaned_r : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_valid_r) else $error("result not presented");
  a_can_mut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && can_mut |-> can_share) else $error("can_mut without can_share");
  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !entry_found |-> owner_out == '0 && borrow_total_out == '0)
    else $error("absent entry with contents");
`endif

endmodule

// File: rtl/resource_borrow_tracker.sv
// top level of the resource borrow tracker
//
// channel | dir | tdata                                    | tuser
// in_     | in  | resource_key, first_proc, second_proc     | command
// out_    | out | status .. cleaned_count (101 bits used)  | -
//
// command: the home slot is found by a bit-serial key mod ENTRIES if ENTRIES is
// not a power of two; a hit stops the probe, a miss probes all ENTRIES slots
// cleanup: one read per slot and a write-back of each valid slot
// after reset a clearing pass over all ENTRIES slots runs before the first word
// a new word is taken while the previous result waits in the output register
`timescale 1ns / 1ps

module resource_borrow_tracker import rbt_pkg::*; #(
  parameter int ENTRIES   = 1024,
  parameter int PROC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // resource_key, first_proc, second_proc
  input  logic [3:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // status, entry_found, entry_state_out, owner_out,
                                   // shared_out, mut_borrower_out, borrow_total_out,
                                   // can_share, can_mut, cleaned_count
);

  ctl_t ctl;
  sts_t sts;

  logic [3:0]         status;
  logic               entry_found;
  logic [1:0]         entry_state_out;
  logic [PROC_W-1:0]  owner_out, mut_borrower_out;
  logic [CNT_W-1:0]   shared_out;
  logic [TOTAL_W-1:0] borrow_total_out;
  logic               can_share, can_mut;
  logic [CLEAN_W-1:0] cleaned_count;

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rbt_dp #(
    .ENTRIES   (ENTRIES),
    .PROC_BITS (PROC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .command          (in_tuser),
    .resource_key     (in_tdata[31:0]),
    .first_proc       (in_tdata[47:32]),
    .second_proc      (in_tdata[63:48]),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .status           (status),
    .entry_found      (entry_found),
    .entry_state_out  (entry_state_out),
    .owner_out        (owner_out),
    .shared_out       (shared_out),
    .mut_borrower_out (mut_borrower_out),
    .borrow_total_out (borrow_total_out),
    .can_share        (can_share),
    .can_mut          (can_mut),
    .cleaned_count    (cleaned_count)
  );

  assign out_tdata = {3'b000, cleaned_count, can_mut, can_share, borrow_total_out,
                      mut_borrower_out, shared_out, owner_out, entry_state_out,
                      entry_found, status};

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the resource borrow tracker
`timescale 1ns / 1ps

module tb_top;
  import rbt_pkg::*;

  typedef struct packed {
    logic [2:0]         pad;
    logic [CLEAN_W-1:0] cleaned;
    logic               can_mut;
    logic               can_share;
    logic [TOTAL_W-1:0] total;
    logic [PROC_W-1:0]  mut;
    logic [CNT_W-1:0]   shared;
    logic [PROC_W-1:0]  owner;
    logic [1:0]         mode;
    logic               found;
    logic [3:0]         status;
  } result_word_t;

  class ownership_board;
    localparam int SLOTS = 1024;
    bit                 used [SLOTS];
    logic [KEY_W-1:0]   key_of [SLOTS];
    logic [PROC_W-1:0]  owner_of [SLOTS];
    logic [1:0]         mode_of [SLOTS];
    logic [CNT_W-1:0]   shared_of [SLOTS];
    logic [PROC_W-1:0]  mut_of [SLOTS];
    logic [TOTAL_W-1:0] total_of [SLOTS];
    result_word_t       expected_words [$];
    int                 errors;

    function new();
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      int s;
      for (int n = 0; n < SLOTS; n++) begin
        s = (k % SLOTS + n) % SLOTS;
        if (used[s] && key_of[s] == k) return s;
      end
      return -1;
    endfunction

    function int claim(logic [KEY_W-1:0] k);
      int s;
      for (int n = 0; n < SLOTS; n++) begin
        s = (k % SLOTS + n) % SLOTS;
        if (!used[s]) begin
          used[s] = 1;
          key_of[s] = k;
          owner_of[s] = 0;
          mode_of[s] = MODE_FREE;
          shared_of[s] = 0;
          mut_of[s] = 0;
          total_of[s] = 0;
          return s;
        end
      end
      return -1;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_command(logic [3:0] cmd, logic [KEY_W-1:0] k,
                               logic [PROC_W-1:0] a, logic [PROC_W-1:0] b);
      logic [3:0]   st;
      int           e;
      int           cl;
      result_word_t r;
      st = ST_OK;
      cl = 0;
      case (cmd)
        CMD_QUERY: ;
        CMD_ACQUIRE: begin
          if (a == 0) st = ST_INVALID;
          else begin
            e = lookup(k);
            if (e < 0) e = claim(k);
            if (e < 0) st = ST_FULL;
            else if (mode_of[e] != MODE_FREE) st = ST_HELD;
            else begin
              owner_of[e] = a;
              mode_of[e] = MODE_EXCL;
            end
          end
        end
        CMD_RELEASE, CMD_TRANSFER: begin
          if (a == 0 || (cmd == CMD_TRANSFER && b == 0)) st = ST_INVALID;
          else begin
            e = lookup(k);
            if (e < 0) st = ST_NOTFOUND;
            else if (owner_of[e] != a) st = ST_NOTOWNER;
            else if (shared_of[e] != 0 || mut_of[e] != 0) st = ST_BORROWED;
            else if (cmd == CMD_RELEASE) begin
              owner_of[e] = 0;
              mode_of[e] = MODE_FREE;
            end else owner_of[e] = b;
          end
        end
        CMD_BORROW_SH, CMD_BORROW_MT: begin
          if (a == 0 || b == 0) st = ST_INVALID;
          else begin
            e = lookup(k);
            if (e < 0) st = ST_NOTFOUND;
            else if (owner_of[e] != a) st = ST_NOTOWNER;
            else if (cmd == CMD_BORROW_SH) begin
              if (mut_of[e] != 0) st = ST_MUTBORROW;
              else if (shared_of[e] == SHARED_MAX) st = ST_COUNTFULL;
              else begin
                shared_of[e]++;
                total_of[e]++;
                if (mode_of[e] == MODE_EXCL) mode_of[e] = MODE_SHARED;
              end
            end else begin
              if (shared_of[e] != 0) st = ST_SHAREDBORROW;
              else if (mut_of[e] != 0) st = ST_MUTBORROW;
              else begin
                mut_of[e] = b;
                mode_of[e] = MODE_MUT;
                total_of[e]++;
              end
            end
          end
        end
        CMD_RETURN_SH, CMD_RETURN_MT: begin
          if (b == 0) st = ST_INVALID;
          else begin
            e = lookup(k);
            if (e < 0) st = ST_NOTFOUND;
            else if (cmd == CMD_RETURN_SH) begin
              if (shared_of[e] == 0) st = ST_NOTBORROWED;
              else begin
                shared_of[e]--;
                if (shared_of[e] == 0) mode_of[e] = MODE_EXCL;
              end
            end else begin
              if (mut_of[e] != b) st = ST_NOTBORROWED;
              else begin
                mut_of[e] = 0;
                mode_of[e] = MODE_EXCL;
              end
            end
          end
        end
        CMD_CLEANUP: begin
          if (a == 0) st = ST_INVALID;
          else begin
            for (int s = 0; s < SLOTS; s++) begin
              if (used[s]) begin
                if (owner_of[s] == a) begin
                  owner_of[s] = 0;
                  mode_of[s] = MODE_FREE;
                  shared_of[s] = 0;
                  mut_of[s] = 0;
                  cl++;
                end
                if (mut_of[s] == a) begin
                  mut_of[s] = 0;
                  if (mode_of[s] == MODE_MUT) mode_of[s] = MODE_EXCL;
                  cl++;
                end
                if (mode_of[s] == MODE_FREE && shared_of[s] == 0 && mut_of[s] == 0)
                  used[s] = 0;
              end
            end
          end
        end
        default: st = ST_INVALID;
      endcase
      r = '0;
      r.status = st;
      r.cleaned = (cl > CLEAN_MAX) ? CLEAN_MAX : cl[CLEAN_W-1:0];
      e = lookup(k);
      if (e >= 0) begin
        r.found = 1;
        r.mode = mode_of[e];
        r.owner = owner_of[e];
        r.shared = shared_of[e];
        r.mut = mut_of[e];
        r.total = total_of[e];
        r.can_share = (mode_of[e] != MODE_FREE) && (mut_of[e] == 0);
        r.can_mut = r.can_share && (shared_of[e] == 0);
      end
      expected_words.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(logic [103:0] data);
      result_word_t a;
      result_word_t x;
      a = data;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, data);
        return;
      end
      x = expected_words.pop_front();
      compare("status", x.status, a.status);
      compare("entry_found", x.found, a.found);
      compare("entry_state_out", x.mode, a.mode);
      compare("owner_out", x.owner, a.owner);
      compare("shared_out", x.shared, a.shared);
      compare("mut_borrower_out", x.mut, a.mut);
      compare("borrow_total_out", x.total, a.total);
      compare("can_share", x.can_share, a.can_share);
      compare("can_mut", x.can_mut, a.can_mut);
      compare("cleaned_count", x.cleaned, a.cleaned);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;

  ownership_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [KEY_W-1:0] key_pool [12];

  always #2 clk = ~clk;

  resource_borrow_tracker i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(logic [3:0] cmd, logic [KEY_W-1:0] k,
                           logic [PROC_W-1:0] a, logic [PROC_W-1:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {b, a, k};
    do @(posedge clk); while (!in_tready);
    board.note_command(cmd, k, a, b);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [PROC_W-1:0] pick_proc();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 10) return PROC_W'($urandom);
    return PROC_W'($urandom_range(1, 4));
  endfunction

  task automatic random_words(int n);
    int r;
    logic [3:0] cmd;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = key_pool[$urandom_range(0, 11)];
      if (r < 16) cmd = CMD_ACQUIRE;
      else if (r < 26) cmd = CMD_RELEASE;
      else if (r < 33) cmd = CMD_TRANSFER;
      else if (r < 49) cmd = CMD_BORROW_SH;
      else if (r < 60) cmd = CMD_BORROW_MT;
      else if (r < 73) cmd = CMD_RETURN_SH;
      else if (r < 85) cmd = CMD_RETURN_MT;
      else if (r < 95) cmd = CMD_QUERY;
      else if (r < 97) cmd = CMD_CLEANUP;
      else cmd = 4'($urandom_range(9, 15));
      if (cmd == CMD_QUERY && $urandom_range(99) < 8) k = $urandom;
      send_word(cmd, k, pick_proc(), pick_proc());
    end
  endtask

  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int j = 2; j < 6; j++) key_pool[j] = {22'($urandom), 10'd5};
    key_pool[6] = {22'($urandom), 10'h3ff};
    for (int j = 7; j < 12; j++) key_pool[j] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed checks
    send_word(CMD_QUERY, key_pool[2], 1, 1);
    send_word(CMD_ACQUIRE, key_pool[2], 0, 1);
    send_word(CMD_ACQUIRE, key_pool[2], 1, 0);
    send_word(CMD_ACQUIRE, key_pool[2], 2, 0);
    send_word(CMD_ACQUIRE, key_pool[3], 2, 0);
    send_word(CMD_BORROW_SH, key_pool[2], 1, 0);
    send_word(CMD_BORROW_SH, key_pool[4], 1, 3);
    send_word(CMD_BORROW_SH, key_pool[2], 2, 3);
    send_word(CMD_BORROW_SH, key_pool[2], 1, 3);
    send_word(CMD_BORROW_MT, key_pool[2], 1, 3);
    send_word(CMD_RELEASE, key_pool[2], 1, 0);
    send_word(CMD_RETURN_SH, key_pool[2], 0, 4);
    send_word(CMD_BORROW_MT, key_pool[2], 1, 3);
    send_word(CMD_BORROW_SH, key_pool[2], 1, 4);
    send_word(CMD_RETURN_MT, key_pool[2], 0, 4);
    send_word(CMD_RETURN_SH, key_pool[2], 0, 4);
    send_word(CMD_TRANSFER, key_pool[3], 2, 0);
    send_word(CMD_CLEANUP, key_pool[3], 0, 0);
    send_word(4'd15, key_pool[3], 2, 2);
    send_word(CMD_ACQUIRE, key_pool[1], 16'hffff, 16'hffff);
    send_word(CMD_TRANSFER, key_pool[1], 16'hffff, 16'hffff);
    send_word(CMD_ACQUIRE, key_pool[6], 2, 0);
    send_word(CMD_RELEASE, key_pool[3], 2, 0);
    send_word(CMD_CLEANUP, key_pool[2], 3, 0);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_words(210); drain();
    send_idle_pct = 50; recv_stall_pct = 0;  random_words(210); drain();
    send_idle_pct = 0;  recv_stall_pct = 50; random_words(210); drain();
    send_idle_pct = 25; recv_stall_pct = 25; random_words(210); drain();

    repeat (2200) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
